FILE: hw/rtl/aid_pkg.sv
// ----------------------------------------------------------------------------
// aid_pkg
// shared types, constants and register codes of the impact detector
// ----------------------------------------------------------------------------
package aid_pkg;

    // sample and configuration field widths
    localparam int SAMPLE_BITS = 13;
    localparam int THR_BITS    = 13;
    localparam int PERIOD_BITS = 10;

    // register file
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // reset values
    localparam logic [THR_BITS-1:0]    MINOR_RESET  = THR_BITS'(200);
    localparam logic [THR_BITS-1:0]    MAJOR_RESET  = THR_BITS'(300);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(50);
    localparam logic [PERIOD_BITS-1:0] PHASE_RESET  = PERIOD_BITS'(1);

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_MINOR  = 2'd0,
        REG_MAJOR  = 2'd1,
        REG_PERIOD = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_MINOR = 2'd1,
        CAUSE_MAJOR = 2'd2
    } cause_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [2:0]          xyz_t;

    typedef struct packed {
        logic [THR_BITS-1:0]    minor_threshold;
        logic [THR_BITS-1:0]    major_threshold;
        logic [PERIOD_BITS-1:0] refresh_period;
    } cfg_t;

    typedef struct packed {
        xyz_t                   reference_xyz;
        xyz_t                   previous_xyz;
        logic [PERIOD_BITS-1:0] refresh_phase;
        logic                   alarm_latched;
        cause_t                 latched_cause;
    } state_t;

    typedef struct packed {
        logic   alarm;
        cause_t cause;
    } result_t;

endpackage

FILE: hw/rtl/aid_regs.sv
// ----------------------------------------------------------------------------
// aid_regs
// apb register file: minor threshold, major threshold, refresh period
// ----------------------------------------------------------------------------
module aid_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aid_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [aid_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [aid_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                             pready,
    output aid_pkg::cfg_t                    cfg
);

    aid_pkg::cfg_t     cfg_reg;
    aid_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = aid_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.minor_threshold <= aid_pkg::MINOR_RESET;
            cfg_reg.major_threshold <= aid_pkg::MAJOR_RESET;
            cfg_reg.refresh_period  <= aid_pkg::PERIOD_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                aid_pkg::REG_MINOR:
                    cfg_reg.minor_threshold <= pwdata[aid_pkg::THR_BITS-1:0];
                aid_pkg::REG_MAJOR:
                    cfg_reg.major_threshold <= pwdata[aid_pkg::THR_BITS-1:0];
                aid_pkg::REG_PERIOD:
                    cfg_reg.refresh_period <= pwdata[aid_pkg::PERIOD_BITS-1:0];
                default:
                begin
                    // unmapped address, write ignored
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            aid_pkg::REG_MINOR:
                prdata = aid_pkg::APB_DATA_BITS'(cfg_reg.minor_threshold);
            aid_pkg::REG_MAJOR:
                prdata = aid_pkg::APB_DATA_BITS'(cfg_reg.major_threshold);
            aid_pkg::REG_PERIOD:
                prdata = aid_pkg::APB_DATA_BITS'(cfg_reg.refresh_period);
            default:
                prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/aid_eval.sv
// ----------------------------------------------------------------------------
// aid_eval
// per-sample decision: delta vote against the reference, alarm latch and
// reference refresh phase
// ----------------------------------------------------------------------------
module aid_eval (
    input  aid_pkg::xyz_t    sample,
    input  aid_pkg::state_t  cur,
    input  aid_pkg::cfg_t    cfg,
    output aid_pkg::state_t  nxt,
    output aid_pkg::result_t res
);

    localparam int DIFF_BITS = aid_pkg::SAMPLE_BITS + 1;
    localparam int CMP_BITS  = (DIFF_BITS > aid_pkg::THR_BITS) ? DIFF_BITS : aid_pkg::THR_BITS;

    logic signed [DIFF_BITS-1:0] diff      [3];
    logic        [DIFF_BITS-1:0] mag       [3];
    logic        [2:0]           over_minor;
    logic        [2:0]           over_major;
    logic        [2:0]           changed;
    logic                        armed;
    logic                        two_minor;
    logic                        fire;
    logic [aid_pkg::PERIOD_BITS-1:0] phase_a;
    logic [aid_pkg::PERIOD_BITS-1:0] phase_b;

    // modulo increment of the refresh phase
    function automatic logic [aid_pkg::PERIOD_BITS-1:0] phase_step(
        input logic [aid_pkg::PERIOD_BITS-1:0] p,
        input logic [aid_pkg::PERIOD_BITS-1:0] period
    );
        logic [aid_pkg::PERIOD_BITS:0] n;
        n = {1'b0, p} + (aid_pkg::PERIOD_BITS + 1)'(1);
        return (n >= {1'b0, period}) ? '0 : n[aid_pkg::PERIOD_BITS-1:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = $signed({sample[i][aid_pkg::SAMPLE_BITS-1], sample[i]})
                    - $signed({cur.reference_xyz[i][aid_pkg::SAMPLE_BITS-1],
                               cur.reference_xyz[i]});
            mag[i]  = diff[i][DIFF_BITS-1] ? DIFF_BITS'(-diff[i]) : DIFF_BITS'(diff[i]);
            over_minor[i] = CMP_BITS'(mag[i]) > CMP_BITS'(cfg.minor_threshold);
            over_major[i] = CMP_BITS'(mag[i]) > CMP_BITS'(cfg.major_threshold);
            changed[i]    = sample[i] != cur.previous_xyz[i];
        end
    end

    assign armed     = (cur.reference_xyz[0] != '0) || (cur.reference_xyz[1] != '0)
                    || (cur.reference_xyz[2] != '0);
    assign two_minor = (over_minor[0] && over_minor[1]) || (over_minor[0] && over_minor[2])
                    || (over_minor[1] && over_minor[2]);
    assign fire      = armed && (two_minor || (over_major != '0));

    // refresh on phase zero, then one more step when every axis moved
    assign phase_a = (cur.refresh_phase == '0) ?
                     phase_step(cur.refresh_phase, cfg.refresh_period) : cur.refresh_phase;
    assign phase_b = (changed == 3'b111) ? phase_step(phase_a, cfg.refresh_period) : phase_a;

    always_comb
    begin
        nxt = cur;
        if (cur.alarm_latched)
        begin
            res.alarm = 1'b1;
            res.cause = cur.latched_cause;
        end
        else if (fire)
        begin
            nxt.alarm_latched = 1'b1;
            nxt.latched_cause = two_minor ? aid_pkg::CAUSE_MINOR : aid_pkg::CAUSE_MAJOR;
            res.alarm         = 1'b1;
            res.cause         = nxt.latched_cause;
        end
        else
        begin
            if (cur.refresh_phase == '0)
            begin
                nxt.reference_xyz = sample;
            end
            nxt.refresh_phase = phase_b;
            nxt.previous_xyz  = sample;
            res.alarm         = 1'b0;
            res.cause         = aid_pkg::CAUSE_NONE;
        end
    end

endmodule

FILE: hw/rtl/accel_impact_detector_top.sv
// ----------------------------------------------------------------------------
// accel_impact_detector_top
// three-axis impact detector with latched alarm and periodic reference refresh
// ----------------------------------------------------------------------------
// pipeline: the accepted sample is captured in the input register, then its
//   result in the result register; the decision logic sits between them
// throughput: one transaction per cycle while out_stall is low, limited by
//   the single result register and the state update done in the same cycle
//   the result is loaded
// reset: rst_n clears both pipeline valids, the detector state (reference and
//   previous sample zero, phase one, no alarm) and loads the register defaults
module accel_impact_detector_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aid_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [aid_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [aid_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    // sample input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [aid_pkg::SAMPLE_BITS-1:0] sample_x,
    input  logic signed [aid_pkg::SAMPLE_BITS-1:0] sample_y,
    input  logic signed [aid_pkg::SAMPLE_BITS-1:0] sample_z,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                alarm,
    output logic [1:0]                          cause
);

    aid_pkg::cfg_t    cfg;
    aid_pkg::xyz_t    s1_sample_reg;
    logic             s1_valid_reg;
    aid_pkg::state_t  state_reg;
    aid_pkg::state_t  state_next;
    aid_pkg::result_t res_next;
    logic             out_valid_reg;
    logic             alarm_reg;
    aid_pkg::cause_t  cause_reg;
    logic             in_accept;
    logic             out_load;
    logic             pipe_move;

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    aid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    // result register can take a new value when empty or being drained
    assign out_load  = !out_valid_reg || !out_stall;
    // the registered sample moves into the result stage and updates state
    assign pipe_move = s1_valid_reg && out_load;
    // input register frees up whenever its content moves on
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (pipe_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg[0] <= sample_x;
            s1_sample_reg[1] <= sample_y;
            s1_sample_reg[2] <= sample_z;
        end
    end

    // ------------------------------------------------------------------
    // decision logic
    // ------------------------------------------------------------------
    aid_eval u_eval (
        .sample (s1_sample_reg),
        .cur    (state_reg),
        .cfg    (cfg),
        .nxt    (state_next),
        .res    (res_next)
    );

    // ------------------------------------------------------------------
    // detector state, updated once per transaction as it leaves stage one
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.reference_xyz <= '0;
            state_reg.previous_xyz  <= '0;
            state_reg.refresh_phase <= aid_pkg::PHASE_RESET;
            state_reg.alarm_latched <= 1'b0;
            state_reg.latched_cause <= aid_pkg::CAUSE_NONE;
        end
        else if (pipe_move)
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_move)
        begin
            alarm_reg <= res_next.alarm;
            cause_reg <= res_next.cause;
        end
    end

    assign out_valid = out_valid_reg;
    assign alarm     = alarm_reg;
    assign cause     = cause_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // once latched, the alarm holds until reset
    a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.alarm_latched |=> state_reg.alarm_latched)
        else $error("alarm latch cleared without reset");

    // while latched, the reference sample is frozen
    a_ref_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.alarm_latched |=> $stable(state_reg.reference_xyz))
        else $error("reference changed while alarm latched");

    // a delivered result has a cause exactly when it raises the alarm
    a_cause_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (alarm_reg == (cause_reg != aid_pkg::CAUSE_NONE)))
        else $error("alarm and cause disagree");

    // input stalls only while stage one holds a transaction
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked transaction");

    // state only changes when a transaction moves to the result stage
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_move |=> $stable(state_reg))
        else $error("detector state changed without a transaction");

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the three-axis impact detector: samples go in over
// the valid/stall channel, a local predictor of the detector state works out
// the alarm and cause of every transaction, and a checker compares each result
// transaction against the oldest prediction; register settings change between
// phases through the apb port, and the alarm is fired once near the end since
// it stays latched until reset
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXIS_MAX       = 2 ** (aid_pkg::SAMPLE_BITS - 1) - 1;
    localparam int THR_MAX        = 2 ** aid_pkg::THR_BITS - 1;
    localparam int PERIOD_MAX     = 2 ** aid_pkg::PERIOD_BITS - 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 250;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                   psel    = 1'b0;
    logic                                   penable = 1'b0;
    logic                                   pwrite  = 1'b0;
    logic [aid_pkg::APB_ADDR_BITS-1:0]      paddr   = '0;
    logic [aid_pkg::APB_DATA_BITS-1:0]      pwdata  = '0;
    logic [aid_pkg::APB_DATA_BITS-1:0]      prdata;
    logic                                   pready;

    logic                                   in_valid  = 1'b0;
    logic                                   in_stall;
    logic signed [aid_pkg::SAMPLE_BITS-1:0] sample_x  = '0;
    logic signed [aid_pkg::SAMPLE_BITS-1:0] sample_y  = '0;
    logic signed [aid_pkg::SAMPLE_BITS-1:0] sample_z  = '0;

    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic                                   alarm;
    logic [1:0]                             cause;

    always #5 clk = ~clk;

    accel_impact_detector_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_x  (sample_x),
        .sample_y  (sample_y),
        .sample_z  (sample_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .alarm     (alarm),
        .cause     (cause)
    );

    // ------------------------------------------------------------------------
    // detector predictor: register shadows and state, at reset values
    // ------------------------------------------------------------------------
    logic [aid_pkg::THR_BITS-1:0]    cfg_minor    = aid_pkg::MINOR_RESET;
    logic [aid_pkg::THR_BITS-1:0]    cfg_major    = aid_pkg::MAJOR_RESET;
    logic [aid_pkg::PERIOD_BITS-1:0] cfg_period   = aid_pkg::PERIOD_RESET;
    aid_pkg::xyz_t                   ref_xyz      = '0;
    aid_pkg::xyz_t                   prev_xyz     = '0;
    logic [aid_pkg::PERIOD_BITS-1:0] pred_phase   = aid_pkg::PHASE_RESET;
    logic                            pred_latched = 1'b0;
    aid_pkg::cause_t                 pred_cause   = aid_pkg::CAUSE_NONE;

    // predicted results still waiting for their transaction on the output
    aid_pkg::result_t alarm_queue[$];

    int errors          = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    function automatic int axis_val(aid_pkg::sample_t v);
        return int'($signed(v));
    endfunction

    function automatic aid_pkg::sample_t to_axis(int v);
        if (v > AXIS_MAX)
            v = AXIS_MAX;
        if (v < -AXIS_MAX - 1)
            v = -AXIS_MAX - 1;
        return aid_pkg::sample_t'(v);
    endfunction

    // decision against the stored reference, without touching any state
    function automatic aid_pkg::cause_t impact_cause(aid_pkg::xyz_t s);
        int over_minor;
        bit over_major;
        int d;
        over_minor = 0;
        over_major = 1'b0;
        // an all-zero reference means detection is not armed yet
        if (ref_xyz == '0)
            return aid_pkg::CAUSE_NONE;
        for (int k = 0; k < 3; k++)
        begin
            d = axis_val(s[k]) - axis_val(ref_xyz[k]);
            if (d < 0)
                d = -d;
            if (d > int'(cfg_minor))
                over_minor++;
            if (d > int'(cfg_major))
                over_major = 1'b1;
        end
        if (over_minor >= 2)
            return aid_pkg::CAUSE_MINOR;
        if (over_major)
            return aid_pkg::CAUSE_MAJOR;
        return aid_pkg::CAUSE_NONE;
    endfunction

    function automatic void advance_phase();
        int nxt;
        nxt = int'(pred_phase) + 1;
        // wraps also when the phase sits above a newly written, smaller period
        if (nxt >= int'(cfg_period))
            pred_phase = '0;
        else
            pred_phase = aid_pkg::PERIOD_BITS'(nxt);
    endfunction

    // one accepted sample: expected result and the state update it causes
    function automatic aid_pkg::result_t judge_sample(aid_pkg::xyz_t s);
        aid_pkg::result_t r;
        aid_pkg::cause_t  c;
        r.alarm = 1'b1;
        if (pred_latched)
        begin
            r.cause = pred_cause;
            return r;
        end
        c = impact_cause(s);
        if (c != aid_pkg::CAUSE_NONE)
        begin
            // firing leaves reference, previous sample and phase alone
            pred_latched = 1'b1;
            pred_cause   = c;
            r.cause      = c;
            return r;
        end
        if (pred_phase == '0)
        begin
            ref_xyz = s;
            advance_phase();
        end
        if (s[0] != prev_xyz[0] && s[1] != prev_xyz[1] && s[2] != prev_xyz[2])
            advance_phase();
        prev_xyz = s;
        r.alarm  = 1'b0;
        r.cause  = aid_pkg::CAUSE_NONE;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sample generation
    // ------------------------------------------------------------------------

    // offsets cluster on the threshold edges, where the compares decide
    function automatic int pick_offset();
        int mag;
        case ($urandom_range(7))
            0:       mag = int'(cfg_minor);
            1:       mag = int'(cfg_minor) + 1;
            2:       mag = int'(cfg_major);
            3:       mag = int'(cfg_major) + 1;
            default: mag = $urandom_range(int'(cfg_minor));
        endcase
        return $urandom_range(1) ? mag : -mag;
    endfunction

    function automatic aid_pkg::xyz_t random_sample();
        aid_pkg::xyz_t s;
        int            mode;
        int            keep;
        mode = $urandom_range(9);
        keep = $urandom_range(2);
        for (int k = 0; k < 3; k++)
        begin
            if (mode >= 8)
                s[k] = aid_pkg::sample_t'($urandom);
            else if (mode == 7 || (mode == 6 && k == keep))
                s[k] = prev_xyz[k];
            else
                s[k] = to_axis(axis_val(ref_xyz[k]) + pick_offset());
        end
        return s;
    endfunction

    // a random sample that keeps the alarm quiet; the reference itself never fires
    function automatic aid_pkg::xyz_t quiet_sample();
        aid_pkg::xyz_t s;
        for (int k = 0; k < 8; k++)
        begin
            s = random_sample();
            if (impact_cause(s) == aid_pkg::CAUSE_NONE)
                return s;
        end
        return ref_xyz;
    endfunction

    // base moved by d, kept in range and, for nonzero d, away from zero (d up to 2000)
    function automatic aid_pkg::sample_t shifted_axis(aid_pkg::sample_t base, int d);
        int v;
        v = axis_val(base) + d;
        if (v > AXIS_MAX || v == 0)
            v = axis_val(base) - d;
        return aid_pkg::sample_t'(v);
    endfunction

    // ------------------------------------------------------------------------
    // result checker: every output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_result
        aid_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (alarm_queue.size() == 0)
            begin
                $error("unexpected result: alarm %0d cause %0d", alarm, cause);
                errors++;
            end
            else
            begin
                want = alarm_queue.pop_front();
                if (alarm !== want.alarm)
                begin
                    $error("alarm: expected %0d, got %0d", want.alarm, alarm);
                    errors++;
                end
                if (cause !== want.cause)
                begin
                    $error("cause: expected %0d, got %0d", want.cause, cause);
                    errors++;
                end
            end
            results_checked++;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: too long without any transaction or register access
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", alarm_queue.size());
            $display("accel_impact_detector_top: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------------
    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 86; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:       begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // one sample transaction; the prediction is queued once it is accepted
    task automatic send_sample(aid_pkg::xyz_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_x <= s[0];
        sample_y <= s[1];
        sample_z <= s[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        alarm_queue.push_back(judge_sample(s));
        samples_sent++;
    endtask

    task automatic send_xyz(int x, int y, int z);
        aid_pkg::xyz_t s;
        s[0] = to_axis(x);
        s[1] = to_axis(y);
        s[2] = to_axis(z);
        send_sample(s);
    endtask

    // every result is in and the pipeline has had time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (alarm_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup, then access until pready, then back to idle
    task automatic reg_write(aid_pkg::reg_idx_t idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= aid_pkg::APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= aid_pkg::APB_DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            aid_pkg::REG_MINOR:  cfg_minor  = aid_pkg::THR_BITS'(value);
            aid_pkg::REG_MAJOR:  cfg_major  = aid_pkg::THR_BITS'(value);
            aid_pkg::REG_PERIOD: cfg_period = aid_pkg::PERIOD_BITS'(value);
            default:             ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(int minor, int major, int period_v);
        wait_idle();
        reg_write(aid_pkg::REG_MINOR, minor);
        reg_write(aid_pkg::REG_MAJOR, major);
        reg_write(aid_pkg::REG_PERIOD, period_v);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero thresholds, but the reference is still all zeros: never an alarm;
    // field extremes and alternating bit patterns on every axis
    task automatic test_unarmed();
        set_idle(IDLE_NONE);
        apply_config(0, 0, aid_pkg::PERIOD_RESET);
        send_xyz(AXIS_MAX, AXIS_MAX, AXIS_MAX);
        send_xyz(-AXIS_MAX - 1, -AXIS_MAX - 1, -AXIS_MAX - 1);
        send_xyz(AXIS_MAX, -AXIS_MAX - 1, 0);
        send_xyz(-AXIS_MAX - 1, 0, AXIS_MAX);
        send_xyz(2730, -2731, 2730);
        send_xyz(-2731, 2730, -2731);
        send_xyz(0, 0, 0);
        send_xyz(-1, 1, -1);
    endtask

    // thresholds at maximum so nothing fires; walk the refresh phase through
    // the smallest periods, zero and one, the largest, and a shrink below it
    task automatic test_phase_wrap();
        apply_config(THR_MAX, THR_MAX, 2);
        send_xyz(100, 200, 300);
        send_xyz(101, 201, 301);
        send_xyz(101, 205, 302);    // one axis unchanged, so only the refresh step
        send_xyz(0, 0, 0);          // phase wraps to zero; the next sample refreshes to an all-zero reference
        send_xyz(0, 0, 0);
        send_xyz(-5, 7, 9);
        apply_config(THR_MAX, THR_MAX, 0);
        send_xyz(1, 2, 3);
        send_xyz(4, 5, 6);
        send_xyz(4, 5, 7);
        apply_config(THR_MAX, THR_MAX, 1);
        send_xyz(10, 20, 30);
        send_xyz(11, 21, 31);
        apply_config(THR_MAX, THR_MAX, PERIOD_MAX);
        send_xyz(1, 1, 1);
        send_xyz(2, 2, 2);
        send_xyz(3, 3, 3);
        send_xyz(4, 4, 4);
        // phase now above the new period
        apply_config(THR_MAX, THR_MAX, 3);
        send_xyz(5, 5, 5);
        send_xyz(6, 6, 6);
    endtask

    // receiver holds off while the sender keeps offering, so the block fills
    task automatic test_backpressure();
        set_idle(IDLE_NONE);
        hold_left = 60;
        repeat (30) send_sample(quiet_sample());
    endtask

    // random phases, each with fresh register settings and its own idle mode;
    // samples sit near the reference and the thresholds, firing ones are dropped
    task automatic test_random_stream();
        idle_mode_t modes[RANDOM_PHASES];
        int         minor;
        int         major;
        int         period_v;
        modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            minor = $urandom_range(30, 1500);
            major = $urandom_range(2) == 0 ? $urandom_range(minor) :
                                             $urandom_range(minor, 3000);
            case ($urandom_range(5))
                0:       period_v = 2;
                1:       period_v = 3;
                2:       period_v = 7;
                3:       period_v = 50;
                4:       period_v = PERIOD_MAX;
                default: period_v = $urandom_range(2, 100);
            endcase
            apply_config(minor, major, period_v);
            set_idle(modes[p]);
            repeat (PHASE_ITEMS) send_sample(quiet_sample());
        end
    endtask

    // arm, send near misses on both thresholds, fire once with a random cause
    // (two over minor, one over major, or both at once where minor wins), then
    // show that the alarm stays latched whatever comes in or gets configured
    task automatic test_alarm_latch();
        aid_pkg::xyz_t s;
        int            minor;
        int            major;
        int            a;
        int            b;
        int            pick;
        set_idle(IDLE_BOTH);
        apply_config(THR_MAX, THR_MAX, 2);
        while (ref_xyz == '0)
        begin
            for (int k = 0; k < 3; k++)
                s[k] = aid_pkg::sample_t'($urandom);
            send_sample(s);
        end
        minor = $urandom_range(50, 900);
        major = $urandom_range(minor + 50, 1999);
        apply_config(minor, major, $urandom_range(2, 10));

        // every delta exactly on the minor limit
        for (int k = 0; k < 3; k++)
            s[k] = shifted_axis(ref_xyz[k], minor);
        send_sample(s);
        // one delta exactly on the major limit
        a = $urandom_range(2);
        for (int k = 0; k < 3; k++)
            s[k] = shifted_axis(ref_xyz[k], (k == a) ? major : 0);
        send_sample(s);

        a    = $urandom_range(2);
        b    = (a + 1) % 3;
        pick = $urandom_range(2);
        for (int k = 0; k < 3; k++)
        begin
            case (pick)
                0:       s[k] = shifted_axis(ref_xyz[k], (k == a || k == b) ? minor + 1 : 0);
                1:       s[k] = shifted_axis(ref_xyz[k], (k == a) ? major + 1 : 0);
                default: s[k] = shifted_axis(ref_xyz[k], major + 1);
            endcase
        end
        send_sample(s);

        repeat (15) send_sample(random_sample());
        apply_config(0, 0, PERIOD_MAX);
        set_idle(IDLE_NONE);
        repeat (15) send_sample(random_sample());
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unarmed();
        test_phase_wrap();
        test_backpressure();
        test_random_stream();
        test_alarm_latch();
        wait_idle();

        $display("ran %0d sample transactions, %0d results checked, through",
                 samples_sent, results_checked);
        $display("unarmed, refresh wrap, hold-off, random and latch phases; cause %s",
                 pred_cause.name());
        if (errors == 0)
            $display("accel_impact_detector_top: match");
        else
            $display("accel_impact_detector_top: mismatch");
        $finish;
    end

endmodule
